// ----- hdl/indexed_array_insert_delete_defines.svh -----
// assertion macros for the indexed array block and its checker
// expects clk and rst_n in the scope where a macro is used
`ifndef INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define INDEXED_ARRAY_INSERT_DELETE_DEFINES_SVH

// condition implies property in the same cycle
`define IAID_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("iaid check failed in the same cycle");

// condition implies property in the next cycle
`define IAID_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("iaid check failed in the following cycle");

`endif

// ----- hdl/iaid_pkg.sv -----
// shared types and constants for the indexed array insert/delete block
// no dependencies
package iaid_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int ITEM_WIDTH_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 6;
  localparam int CAP_W   = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BOUND    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_ITEM_WR,
    S_RESULT,
    S_DISP_RD,
    S_DISP_OUT
  } state_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  item;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  element_value;
    logic [INDEX_W-1:0]         element_index;
    logic [COUNT_W-1:0]         element_count;
    logic                       last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic st_ld;
    logic idx_init_count;
    logic idx_init_pos;
    logic idx_init_zero;
    logic idx_up;
    logic idx_down;
    logic shift_rd;
    logic shift_wr;
    logic item_wr;
    logic cnt_inc;
    logic cnt_dec;
    logic disp_rd;
    logic emit_result;
    logic emit_elem;
  } dp_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic ins_ok;
    logic ins_tail;
    logic del_ok;
    logic del_tail;
    logic empty;
    logic shift_last;
    logic disp_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/iaid_datapath.sv -----
// datapath: element memory, count, shift index, capacity register and result register
// depends on iaid_pkg
module iaid_datapath #(
  parameter int DEPTH      = iaid_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = iaid_pkg::ITEM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iaid_pkg::dp_ctrl_t            ctrl,
  output iaid_pkg::dp_stat_t            stat,
  input  iaid_pkg::in_item_t            in_data,
  input  logic                          cfg_we,
  input  logic [iaid_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                          out_stall,
  output logic                          out_valid,
  output iaid_pkg::out_item_t           out_data
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > iaid_pkg::POS_W) ? CW : iaid_pkg::POS_W) + 1;

  // latched transaction
  iaid_pkg::cmd_t                    cmd_r;
  logic [iaid_pkg::POS_W-1:0]        pos_r;
  logic signed [iaid_pkg::VALUE_W-1:0] item_r;

  logic [CW-1:0]                     count_r, count_nxt;
  logic [AW-1:0]                     idx_r, idx_nxt;
  logic [iaid_pkg::CAP_W-1:0]        cap_r;
  iaid_pkg::status_t                 st_r, st_nxt;

  logic [ITEM_WIDTH-1:0]             mem_r [DEPTH];
  logic [ITEM_WIDTH-1:0]             rd_data_r;
  logic                              rd_en, wr_en;
  logic [AW-1:0]                     rd_addr, wr_addr;
  logic [ITEM_WIDTH-1:0]             wr_data;

  logic                              out_valid_r, out_valid_nxt;
  iaid_pkg::out_item_t               out_data_r, out_data_nxt;

  logic [CMPW-1:0] pos_x, cnt_x, idx_x, cap_x, dep_x;
  logic            full;

  // widened operands for compares
  assign pos_x = CMPW'(pos_r);
  assign cnt_x = CMPW'(count_r);
  assign idx_x = CMPW'(idx_r);
  assign cap_x = CMPW'(cap_r);
  assign dep_x = CMPW'(DEPTH);
  assign full  = (cnt_x >= cap_x) || (cnt_x >= dep_x);

  // status towards the controller
  always_comb begin
    stat.cmd       = cmd_r;
    stat.ins_ok    = !full && (pos_x <= cnt_x);
    stat.ins_tail  = (pos_x == cnt_x);
    stat.del_ok    = (pos_x < cnt_x);
    stat.del_tail  = (pos_x + CMPW'(1) == cnt_x);
    stat.empty     = (count_r == '0);
    stat.shift_last = (cmd_r == iaid_pkg::CMD_INSERT) ? (idx_x == pos_x + CMPW'(1))
                                                      : (idx_x + CMPW'(2) == cnt_x);
    stat.disp_last = (idx_x + CMPW'(1) == cnt_x);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      cmd_r  <= in_data.cmd;
      pos_r  <= in_data.position;
      item_r <= in_data.item;
    end
  end

  // result status decided once per command
  always_comb begin
    st_nxt = st_r;
    if (ctrl.st_ld) begin
      case (cmd_r)
        iaid_pkg::CMD_INSERT: begin
          if (full)
            st_nxt = iaid_pkg::ST_OVERFLOW;
          else if (pos_x > cnt_x)
            st_nxt = iaid_pkg::ST_BOUND;
          else
            st_nxt = iaid_pkg::ST_OK;
        end
        iaid_pkg::CMD_DELETE: begin
          st_nxt = stat.del_ok ? iaid_pkg::ST_OK : iaid_pkg::ST_BOUND;
        end
        iaid_pkg::CMD_DISPLAY: begin
          st_nxt = stat.empty ? iaid_pkg::ST_EMPTY : iaid_pkg::ST_OK;
        end
        default: begin
          st_nxt = iaid_pkg::ST_OK;
        end
      endcase
    end
  end

  // count and shift index
  always_comb begin
    count_nxt = count_r;
    if (ctrl.cnt_inc)
      count_nxt = count_r + CW'(1);
    else if (ctrl.cnt_dec)
      count_nxt = count_r - CW'(1);

    idx_nxt = idx_r;
    if (ctrl.idx_init_count)
      idx_nxt = AW'(count_r);
    else if (ctrl.idx_init_pos)
      idx_nxt = AW'(pos_r);
    else if (ctrl.idx_init_zero)
      idx_nxt = '0;
    else if (ctrl.idx_up)
      idx_nxt = idx_r + AW'(1);
    else if (ctrl.idx_down)
      idx_nxt = idx_r - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= iaid_pkg::CAP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_we)
        cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    st_r  <= st_nxt;
  end

  // memory port addressing
  always_comb begin
    rd_en   = ctrl.shift_rd || ctrl.disp_rd;
    rd_addr = idx_r;
    if (ctrl.shift_rd)
      rd_addr = (cmd_r == iaid_pkg::CMD_INSERT) ? (idx_r - AW'(1)) : (idx_r + AW'(1));
    wr_en   = ctrl.shift_wr || ctrl.item_wr;
    wr_addr = ctrl.item_wr ? AW'(pos_r) : idx_r;
    wr_data = ctrl.item_wr ? ITEM_WIDTH'(item_r) : rd_data_r;
  end

  // element memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en)
      mem_r[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en)
      rd_data_r <= mem_r[rd_addr];
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (ctrl.emit_result) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status:        st_r,
                        element_value: '0,
                        element_index: '0,
                        element_count: iaid_pkg::COUNT_W'(count_r),
                        last:          1'b1};
    end else if (ctrl.emit_elem) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status:        iaid_pkg::ST_OK,
                        element_value: iaid_pkg::VALUE_W'(signed'(rd_data_r)),
                        element_index: iaid_pkg::INDEX_W'(idx_r),
                        element_count: iaid_pkg::COUNT_W'(count_r),
                        last:          stat.disp_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/iaid_ctrl.sv -----
// controller: sequences insert and delete shifts, display reads and result loads
// depends on iaid_pkg
module iaid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iaid_pkg::dp_stat_t  stat,
  output iaid_pkg::dp_ctrl_t  ctrl
);

  iaid_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= iaid_pkg::S_IDLE;
    else
      state_r <= state_nxt;
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_stall  = (state_r != iaid_pkg::S_IDLE);
    case (state_r)
      iaid_pkg::S_IDLE: begin
        if (in_valid) begin
          ctrl.take = 1'b1;
          state_nxt = iaid_pkg::S_EXEC;
        end
      end
      iaid_pkg::S_EXEC: begin
        ctrl.st_ld = 1'b1;
        state_nxt  = iaid_pkg::S_RESULT;
        case (stat.cmd)
          iaid_pkg::CMD_INSERT: begin
            if (stat.ins_ok) begin
              ctrl.idx_init_count = 1'b1;
              state_nxt = stat.ins_tail ? iaid_pkg::S_ITEM_WR : iaid_pkg::S_SHIFT_RD;
            end
          end
          iaid_pkg::CMD_DELETE: begin
            if (stat.del_ok) begin
              ctrl.idx_init_pos = 1'b1;
              if (stat.del_tail)
                ctrl.cnt_dec = 1'b1;
              else
                state_nxt = iaid_pkg::S_SHIFT_RD;
            end
          end
          iaid_pkg::CMD_DISPLAY: begin
            if (!stat.empty) begin
              ctrl.idx_init_zero = 1'b1;
              state_nxt = iaid_pkg::S_DISP_RD;
            end
          end
          default: begin
            state_nxt = iaid_pkg::S_RESULT;
          end
        endcase
      end
      iaid_pkg::S_SHIFT_RD: begin
        ctrl.shift_rd = 1'b1;
        state_nxt     = iaid_pkg::S_SHIFT_WR;
      end
      iaid_pkg::S_SHIFT_WR: begin
        ctrl.shift_wr = 1'b1;
        state_nxt     = iaid_pkg::S_SHIFT_RD;
        if (stat.cmd == iaid_pkg::CMD_INSERT) begin
          // moving entries up, walking towards the position
          ctrl.idx_down = 1'b1;
          if (stat.shift_last)
            state_nxt = iaid_pkg::S_ITEM_WR;
        end else begin
          // moving entries down, walking towards the tail
          ctrl.idx_up = 1'b1;
          if (stat.shift_last) begin
            ctrl.cnt_dec = 1'b1;
            state_nxt    = iaid_pkg::S_RESULT;
          end
        end
      end
      iaid_pkg::S_ITEM_WR: begin
        ctrl.item_wr = 1'b1;
        ctrl.cnt_inc = 1'b1;
        state_nxt    = iaid_pkg::S_RESULT;
      end
      iaid_pkg::S_RESULT: begin
        if (stat.out_free) begin
          ctrl.emit_result = 1'b1;
          state_nxt        = iaid_pkg::S_IDLE;
        end
      end
      iaid_pkg::S_DISP_RD: begin
        ctrl.disp_rd = 1'b1;
        state_nxt    = iaid_pkg::S_DISP_OUT;
      end
      iaid_pkg::S_DISP_OUT: begin
        if (stat.out_free) begin
          ctrl.emit_elem = 1'b1;
          if (stat.disp_last) begin
            state_nxt = iaid_pkg::S_IDLE;
          end else begin
            ctrl.idx_up = 1'b1;
            state_nxt   = iaid_pkg::S_DISP_RD;
          end
        end
      end
      default: begin
        state_nxt = iaid_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/indexed_array_insert_delete.sv -----
// one transaction at a time; the next can be accepted in the cycle after its last result is loaded
// insert: exec, a shift step per entry at or above the position, item write, result; delete: exec,
// a shift step per entry above the position, result; display: exec, then a read and an output per
// element; refusals and empty display: exec, result; each shift step is a read and then a write on
// the element memory; receiver stalls delay results; synchronous active-low reset clears the
// count to zero and the capacity to 32; element memory is not cleared and needs no clearing pass
module indexed_array_insert_delete #(
  parameter int DEPTH      = iaid_pkg::DEPTH_DEF,
  parameter int ITEM_WIDTH = iaid_pkg::ITEM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  iaid_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output iaid_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [iaid_pkg::CAP_W-1:0]  cfg_wdata
);

  iaid_pkg::dp_ctrl_t ctrl;
  iaid_pkg::dp_stat_t stat;

  // sequencing
  iaid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // storage and result path
  iaid_datapath #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/iaid_checker.sv -----
// port-level checks for the indexed array block, bound to the top level
// depends on iaid_pkg and indexed_array_insert_delete_defines.svh
`include "indexed_array_insert_delete_defines.svh"

module iaid_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input iaid_pkg::out_item_t out_data
);

  logic refused;
  logic empty_shown;

  // result kinds looked at below
  assign refused     = out_valid &&
                       (out_data.status inside {iaid_pkg::ST_OVERFLOW, iaid_pkg::ST_BOUND});
  assign empty_shown = out_valid && (out_data.status == iaid_pkg::ST_EMPTY);

  // a stalled result stays put
  `IAID_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // after a transaction is taken the input side closes until it completes
  `IAID_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

  // refusals give a single result carrying no element
  `IAID_ASSERT_NOW(a_refusal_single, refused, out_data.last && (out_data.element_value == '0))

  // an empty display reports no elements
  `IAID_ASSERT_NOW(a_empty_zero, empty_shown, out_data.last && (out_data.element_count == '0))

endmodule

bind indexed_array_insert_delete iaid_checker u_iaid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/indexed_array_insert_delete_test.sv -----
// self-checking testbench for the indexed array insert/delete block
// depends on iaid_pkg and indexed_array_insert_delete; keeps its own mirror of the array
// covers directed corner cases, capacity settings, a full array under receiver hold-off and random traffic
module indexed_array_insert_delete_test;
  import iaid_pkg::*;

  localparam int ARRAY_DEPTH   = DEPTH_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  // mirror of the array contents, count and capacity
  logic signed [VALUE_W-1:0] mirror_elems [ARRAY_DEPTH];
  int               mirror_count;
  logic [CAP_W-1:0] mirror_capacity;

  out_item_t pending_results [$];
  int        mismatch_count;
  int        cycle_count;
  int        burst_left;
  bit        hold_request;

  indexed_array_insert_delete DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run time limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("indexed_array_insert_delete test failed");
    $finish;
  end

  // capacity as the block applies it
  function automatic int capacity_limit();
    return (int'(mirror_capacity) > ARRAY_DEPTH) ? ARRAY_DEPTH : int'(mirror_capacity);
  endfunction

  // expected results of one accepted transaction, mirror updated in place
  task automatic apply_array_command(input in_item_t t);
    out_item_t r;
    int        pos;
    r = '0;
    r.last = 1'b1;
    pos = int'(t.position);
    case (t.cmd)
      CMD_INSERT: begin
        if (mirror_count >= capacity_limit()) begin
          r.status = ST_OVERFLOW;
        end else if (pos > mirror_count || pos >= ARRAY_DEPTH) begin
          r.status = ST_BOUND;
        end else begin
          for (int i = mirror_count; i > pos; i--) mirror_elems[i] = mirror_elems[i-1];
          mirror_elems[pos] = t.item;
          mirror_count++;
          r.status = ST_OK;
        end
        r.element_count = COUNT_W'(mirror_count);
        pending_results.push_back(r);
      end
      CMD_DELETE: begin
        if (pos >= mirror_count) begin
          r.status = ST_BOUND;
        end else begin
          for (int i = pos; i + 1 < mirror_count; i++) mirror_elems[i] = mirror_elems[i+1];
          mirror_count--;
          r.status = ST_OK;
        end
        r.element_count = COUNT_W'(mirror_count);
        pending_results.push_back(r);
      end
      CMD_DISPLAY: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < mirror_count; i++) begin
            r.status        = ST_OK;
            r.element_value = mirror_elems[i];
            r.element_index = INDEX_W'(i);
            r.element_count = COUNT_W'(mirror_count);
            r.last          = (i == mirror_count - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
        // unused code leaves everything alone
        r.status = ST_OK;
        r.element_count = COUNT_W'(mirror_count);
        pending_results.push_back(r);
      end
    endcase
  endtask

  // sender gap: bursts with no idling, mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // item values lean towards the extremes now and then
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // one input transaction; valid stays high after acceptance until the next call decides
  task automatic issue_command(input cmd_t c, input int pos, input logic [VALUE_W-1:0] value);
    in_item_t t;
    int       gap;
    t.cmd      = c;
    t.position = POS_W'(pos);
    t.item     = value;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_array_command(t);
  endtask

  // stop sending and let every result come back
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror_capacity = value;
  endtask

  // corner cases at the reset capacity
  task automatic test_directed();
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_DELETE, 0, 32'h0);
    issue_command(CMD_DELETE, 255, 32'hffff_ffff);
    issue_command(CMD_INSERT, 1, 32'h1234_5678);
    issue_command(CMD_INSERT, 255, 32'h1234_5678);
    issue_command(CMD_INSERT, 0, 32'h7fff_ffff);
    issue_command(CMD_INSERT, 0, 32'h8000_0000);
    issue_command(CMD_INSERT, 2, 32'hffff_ffff);
    issue_command(CMD_INSERT, 1, 32'h0000_0000);
    issue_command(CMD_INSERT, 4, 32'h5a5a_a5a5);
    issue_command(CMD_NOP, 255, 32'hffff_ffff);
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_DELETE, 2, 32'h0);
    issue_command(CMD_DELETE, 0, 32'h0);
    issue_command(CMD_DELETE, 2, 32'h0);
    issue_command(CMD_DELETE, 2, 32'h0);
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_INSERT, 3, 32'h0000_0001);
    issue_command(CMD_INSERT, 2, 32'h0000_0001);
    issue_command(CMD_DISPLAY, 0, 32'h0);
  endtask

  // zero capacity and capacity lowered below the count
  task automatic test_capacity_limits();
    write_capacity(6'd0);
    issue_command(CMD_INSERT, 0, 32'h1111_1111);
    issue_command(CMD_INSERT, 255, 32'h2222_2222);
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_DELETE, 1, 32'h0);
    write_capacity(6'd1);
    issue_command(CMD_INSERT, 0, 32'h3333_3333);
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_DELETE, 0, 32'h0);
    issue_command(CMD_INSERT, 1, 32'h4444_4444);
    issue_command(CMD_DELETE, 0, 32'h0);
    write_capacity(6'd0);
    issue_command(CMD_INSERT, 0, 32'h5555_5555);
    issue_command(CMD_DISPLAY, 0, 32'h0);
  endtask

  // capacity above depth, full array, long receiver hold-off
  task automatic test_full_array_pressure();
    write_capacity(6'd63);
    while (mirror_count < ARRAY_DEPTH)
      issue_command(CMD_INSERT, $urandom_range(0, mirror_count), pick_value());
    issue_command(CMD_INSERT, 0, 32'h6666_6666);
    issue_command(CMD_INSERT, 200, 32'h7777_7777);
    hold_request = 1'b1;
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_DELETE, 0, 32'h0);
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_NOP, 0, 32'h0);
    issue_command(CMD_DELETE, 31, 32'h0);
    issue_command(CMD_INSERT, 31, 32'h8000_0001);
    issue_command(CMD_DISPLAY, 0, 32'h0);
    issue_command(CMD_DELETE, 5, 32'h0);
    issue_command(CMD_DELETE, 5, 32'h0);
    issue_command(CMD_DISPLAY, 0, 32'h0);
  endtask

  // mostly well-formed traffic kept between empty and full, with some noise
  task automatic run_random_phase(input int n);
    int   roll;
    int   pos;
    int   insert_odds;
    cmd_t c;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      insert_odds = (mirror_count < capacity_limit() / 2) ? 70 : 45;
      if (roll < 12) begin
        c   = cmd_t'($urandom_range(0, 3));
        pos = $urandom_range(0, 255);
      end else if (roll < 20) begin
        c   = CMD_DISPLAY;
        pos = $urandom_range(0, 255);
      end else if (mirror_count == 0 ||
                   (roll < insert_odds && mirror_count < capacity_limit())) begin
        c   = CMD_INSERT;
        pos = $urandom_range(0, mirror_count);
      end else begin
        c   = CMD_DELETE;
        pos = $urandom_range(0, mirror_count - 1);
      end
      issue_command(c, pos, pick_value());
    end
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [7];
    caps = '{6'd17, 6'd63, 6'd1, 6'd32, 6'd0, 6'd33, 6'd8};
    caps[4] = CAP_W'($urandom_range(0, 63));
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      run_random_phase(40);
    end
  endtask

  // receiver stall: random runs, calm stretches and a counted hold-off on request
  initial begin : receiver_stall
    int hold_left;
    int run_left;
    bit run_val;
    hold_left = 0;
    run_left  = 0;
    run_val   = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 9))
            0: begin
              run_val  = 1'b0;
              run_left = $urandom_range(20, 60);
            end
            1, 2, 3: begin
              run_val  = 1'b1;
              run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            end
            default: begin
              run_val  = 1'b0;
              run_left = $urandom_range(1, 6);
            end
          endcase
        end
        run_left--;
        out_stall <= run_val;
      end
    end
  end

  // compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d value %0d count %0d",
               out_data.status, out_data.element_value, out_data.element_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.element_value !== want.element_value) begin
          $error("element_value: expected %0d, got %0d", want.element_value,
                 out_data.element_value);
          mismatch_count++;
        end
        if (out_data.element_index !== want.element_index) begin
          $error("element_index: expected %0d, got %0d", want.element_index,
                 out_data.element_index);
          mismatch_count++;
        end
        if (out_data.element_count !== want.element_count) begin
          $error("element_count: expected %0d, got %0d", want.element_count,
                 out_data.element_count);
          mismatch_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  // reset, test sequence and final verdict
  initial begin
    mismatch_count  = 0;
    burst_left      = 0;
    hold_request    = 1'b0;
    mirror_count    = 0;
    mirror_capacity = CAP_RESET;
    foreach (mirror_elems[i]) mirror_elems[i] = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity_limits();
    test_full_array_pressure();
    test_random_traffic();

    drain_block();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("indexed_array_insert_delete test passed");
    end else begin
      $display("indexed_array_insert_delete test failed");
    end
    $finish;
  end

endmodule
